@@ hw/rtl/tog_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tog_pkg
// Shared types and codes of the tuple odometer generator.
// ----------------------------------------------------------------------------
package tog_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int RC_W        = 16;
    localparam int OUT_W       = 16;
    localparam int COUNT_W     = 3;
    localparam int OUT_COLUMNS = 6;

    typedef enum logic [1:0] {
        MODE_PRODUCT   = 2'd0,
        MODE_SEQUENCE  = 2'd1,
        MODE_ASCENDING = 2'd2,
        MODE_PRODUCT_B = 2'd3
    } t_mode;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT_0  = 3'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEQ_CHECK,
        ST_SEQ_WRITE,
        ST_CARRY,
        ST_FIX,
        ST_FINISH
    } t_state;

    // flags of the shared add/compare unit
    typedef struct packed {
        logic ge;   // operand + incr reaches the row count
        logic le;   // other operand not above operand
    } t_cmp_flags;

endpackage

@@ hw/rtl/tog_step_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tog_step_unit
// Shared increment and row-count compare used by every sequencer step.
// ----------------------------------------------------------------------------
module tog_step_unit #(
    parameter int ROW_BITS = 16
) (
    input  logic [ROW_BITS-1:0]      i_operand,
    input  logic                     i_incr,
    input  logic [tog_pkg::RC_W-1:0] i_row_count,
    input  logic [ROW_BITS-1:0]      i_other,
    output logic [ROW_BITS-1:0]      o_sum,
    output tog_pkg::t_cmp_flags      o_flags
);
    import tog_pkg::*;

    localparam int CMP_W = ((ROW_BITS > RC_W) ? ROW_BITS : RC_W) + 1;

    logic [CMP_W-1:0] w_sum;

    assign w_sum       = CMP_W'(i_operand) + CMP_W'(i_incr);
    assign o_sum       = w_sum[ROW_BITS-1:0];
    assign o_flags.ge  = (w_sum >= CMP_W'(i_row_count));
    assign o_flags.le  = (i_other <= i_operand);

endmodule

@@ hw/rtl/tuple_odometer_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuple_odometer_generator
// Product, lockstep and strictly ascending index tuple enumerator.
// ----------------------------------------------------------------------------
// A restart loads, and an advance steps, the columns in use one column per
// cycle through the single add/compare unit; an exhausted advance goes
// straight to the output register. One item at a time: the next item is
// taken once the result sits in the output register. reset: all indices
// zero, not exhausted, mode product, one column, every row count one.
module tuple_odometer_generator #(
    parameter int MAX_COLUMNS = 6,
    parameter int ROW_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tog_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tog_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_valid_res,
    output logic [tog_pkg::OUT_W-1:0]       o_index_0,
    output logic [tog_pkg::OUT_W-1:0]       o_index_1,
    output logic [tog_pkg::OUT_W-1:0]       o_index_2,
    output logic [tog_pkg::OUT_W-1:0]       o_index_3,
    output logic [tog_pkg::OUT_W-1:0]       o_index_4,
    output logic [tog_pkg::OUT_W-1:0]       o_index_5
);
    import tog_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // configuration
    t_mode                r_mode;
    logic [COUNT_W-1:0]   r_col_count;
    logic [RC_W-1:0]      r_row_count [MAX_COLUMNS];

    // enumeration state
    t_state               r_state, n_state;
    logic [ROW_BITS-1:0]  r_idx [MAX_COLUMNS];
    logic                 r_exh, n_exh;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_BITS-1:0]  r_prev, n_prev;

    // output register
    logic                 r_out_valid;
    logic                 r_valid_res;
    logic [OUT_W-1:0]     r_out_idx [OUT_COLUMNS];

    logic [COUNT_W-1:0]   w_n;
    logic                 w_last;
    logic                 w_accept;
    logic                 w_out_take;
    logic                 w_load_out;
    logic                 w_clear_idx;
    logic                 w_idx_we;
    logic [ROW_BITS-1:0]  w_idx_wdata;
    logic [ROW_BITS-1:0]  w_cur;
    logic [RC_W-1:0]      w_cur_rc;
    logic [ROW_BITS-1:0]  w_operand;
    logic                 w_incr;
    logic [ROW_BITS-1:0]  w_sum;
    t_cmp_flags           w_flags;
    logic [OUT_W-1:0]     w_col_out [OUT_COLUMNS];

    assign w_n      = (r_col_count > COUNT_W'(MAX_COLUMNS)) ? COUNT_W'(MAX_COLUMNS)
                                                             : r_col_count;
    assign w_last   = (COUNT_W'(r_col) == (w_n - COUNT_W'(1)));
    assign w_cur    = r_idx[r_col];
    assign w_cur_rc = r_row_count[r_col];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PRODUCT;
            r_col_count <= COUNT_W'(1);
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                r_row_count[c] <= RC_W'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MODE) begin
                r_mode <= t_mode'(i_cfg_data[1:0]);
            end
            if (i_cfg_index == CFG_COLUMN_COUNT) begin
                r_col_count <= i_cfg_data[COUNT_W-1:0];
            end
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                if (i_cfg_index == CFG_ROW_COUNT_0 + CFG_INDEX_W'(c)) begin
                    r_row_count[c] <= i_cfg_data[RC_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------ step unit
    always_comb begin
        w_operand = w_cur;
        w_incr    = 1'b1;
        if (r_state == ST_LOAD) begin
            w_operand = (r_mode == MODE_ASCENDING) ? ROW_BITS'(r_col) : '0;
            w_incr    = 1'b0;
        end else if (r_state == ST_FIX) begin
            w_operand = r_prev;
        end
    end

    tog_step_unit #(
        .ROW_BITS (ROW_BITS)
    ) u_step (
        .i_operand   (w_operand),
        .i_incr      (w_incr),
        .i_row_count (w_cur_rc),
        .i_other     (w_cur),
        .o_sum       (w_sum),
        .o_flags     (w_flags)
    );

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state     = r_state;
        n_exh       = r_exh;
        n_col       = r_col;
        n_prev      = r_prev;
        w_clear_idx = 1'b0;
        w_idx_we    = 1'b0;
        w_idx_wdata = w_sum;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_col = '0;
                    if (i_restart) begin
                        w_clear_idx = 1'b1;
                        n_exh       = (w_n == '0);
                        n_state     = (w_n == '0) ? ST_FINISH : ST_LOAD;
                    end else if (r_exh) begin
                        n_state = ST_FINISH;
                    end else if (w_n == '0) begin
                        n_exh   = 1'b1;
                        n_state = ST_FINISH;
                    end else if (r_mode == MODE_SEQUENCE) begin
                        n_state = ST_SEQ_CHECK;
                    end else begin
                        n_col   = COL_W'(w_n - COUNT_W'(1));
                        n_state = ST_CARRY;
                    end
                end
            end
            ST_LOAD: begin
                if (w_flags.ge) begin
                    n_exh   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    w_idx_we = 1'b1;
                    if (w_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            ST_SEQ_CHECK: begin
                // nothing moves unless every column can step
                if (w_flags.ge) begin
                    n_exh   = 1'b1;
                    n_state = ST_FINISH;
                end else if (w_last) begin
                    n_col   = '0;
                    n_state = ST_SEQ_WRITE;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            ST_SEQ_WRITE: begin
                w_idx_we = 1'b1;
                if (w_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            ST_CARRY: begin
                w_idx_we = 1'b1;
                if (w_flags.ge) begin
                    w_idx_wdata = '0;
                    if (r_col == '0) begin
                        n_exh   = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        n_col = r_col - COL_W'(1);
                    end
                end else if (r_mode == MODE_ASCENDING && !w_last) begin
                    // carry stopped above the last column: fix up ordering
                    n_prev  = (r_col == '0) ? w_sum : r_idx[0];
                    n_col   = COL_W'(1);
                    n_state = ST_FIX;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FIX: begin
                if (w_flags.le && w_flags.ge) begin
                    n_exh   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    if (w_flags.le) begin
                        w_idx_we = 1'b1;
                        n_prev   = w_sum;
                    end else begin
                        n_prev = w_cur;
                    end
                    if (w_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_exh   <= 1'b0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_exh   <= n_exh;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                r_idx[c] <= '0;
            end
        end else if (w_clear_idx) begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                r_idx[c] <= '0;
            end
        end else if (w_idx_we) begin
            r_idx[r_col] <= w_idx_wdata;
        end
    end

    // --------------------------------------------------------------- output
    for (genvar k = 0; k < OUT_COLUMNS; k++) begin : g_col_out
        if (k < MAX_COLUMNS) begin : g_used
            assign w_col_out[k] = (!r_exh && (COUNT_W'(k) < w_n)) ? OUT_W'(r_idx[k]) : '0;
        end else begin : g_unused
            assign w_col_out[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_valid_res <= !r_exh;
            for (int k = 0; k < OUT_COLUMNS; k++) begin
                r_out_idx[k] <= w_col_out[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_valid_res = r_valid_res;
    assign o_index_0   = r_out_idx[0];
    assign o_index_1   = r_out_idx[1];
    assign o_index_2   = r_out_idx[2];
    assign o_index_3   = r_out_idx[3];
    assign o_index_4   = r_out_idx[4];
    assign o_index_5   = r_out_idx[5];

    // ----------------------------------------------------------- assertions
    a_busy_after_transfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input taken while a step is still running");

    a_exhausted_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_restart && r_exh) |=> r_exh)
        else $error("exhaustion cleared without restart");

    a_col_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_FINISH) |-> (COUNT_W'(r_col) < w_n))
        else $error("column pointer beyond columns in use");

    a_exhausted_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_valid_res) |-> (r_out_idx[0] == '0 && r_out_idx[1] == '0
            && r_out_idx[2] == '0 && r_out_idx[3] == '0 && r_out_idx[4] == '0
            && r_out_idx[5] == '0))
        else $error("exhausted result carries nonzero indices");

endmodule

@@ test/tuple_odometer_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuple_odometer_generator_tb
// Self-checking bench for the tuple odometer generator. A behavioral
// enumerator in the bench tracks the index tuple for each accepted item.
// Each tuple the block returns is checked field by field against it.
// Directed sequences cover each mode and the degenerate settings. A random
// walk then mixes configurations, restarts and advances, with bursty input
// and output stalls.
// ----------------------------------------------------------------------------
module tuple_odometer_generator_tb;
    import tog_pkg::*;

    localparam int MAX_COLS       = 6;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic                                valid;
        logic [OUT_COLUMNS-1:0][OUT_W-1:0]   idx;
    } t_tuple;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_restart = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_valid_res;
    logic [OUT_W-1:0]       o_index_0, o_index_1, o_index_2;
    logic [OUT_W-1:0]       o_index_3, o_index_4, o_index_5;

    tuple_odometer_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_valid_res (o_valid_res),
        .o_index_0   (o_index_0),
        .o_index_1   (o_index_1),
        .o_index_2   (o_index_2),
        .o_index_3   (o_index_3),
        .o_index_4   (o_index_4),
        .o_index_5   (o_index_5)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // enumerator state and register copy
    t_mode              cfg_mode = MODE_PRODUCT;
    logic [COUNT_W-1:0] cfg_cols = 3'd1;
    logic [RC_W-1:0]    cfg_rows [MAX_COLS] = '{default: 16'd1};
    logic [RC_W-1:0]    col_idx  [MAX_COLS] = '{default: 16'd0};
    bit                 run_done = 1'b0;

    t_tuple tuple_q [$];

    int error_count    = 0;
    int items_sent     = 0;
    int restarts_sent  = 0;
    int results_seen   = 0;
    int exhausted_seen = 0;
    int configs_loaded = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    bit no_gaps        = 1'b0;
    int stall_style    = 0;
    int stall_left     = 0;
    int stall_phase    = 0;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at tuple %0d: %s got %0d want %0d", results_seen, field, got, want);
        error_count++;
    endtask

    // odometer step of one column, returns 1 on carry
    function automatic bit bump_column(input int c);
        if (int'(col_idx[c]) + 1 >= int'(cfg_rows[c])) begin
            col_idx[c] = '0;
            return 1'b1;
        end
        col_idx[c] = col_idx[c] + 16'd1;
        return 1'b0;
    endfunction

    function automatic t_tuple next_tuple(input logic restart);
        int     n;
        int     k;
        int     prev;
        bit     blocked;
        t_tuple r;
        n = (int'(cfg_cols) > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
        if (restart) begin
            run_done = (n == 0);
            for (k = 0; k < MAX_COLS; k++) begin
                col_idx[k] = '0;
            end
            for (k = 0; k < n; k++) begin
                prev = (cfg_mode == MODE_ASCENDING) ? k : 0;
                col_idx[k] = RC_W'(prev);
                if (prev >= int'(cfg_rows[k])) begin
                    run_done = 1'b1;
                end
            end
        end else if (!run_done) begin
            if (n == 0) begin
                run_done = 1'b1;
            end else if (cfg_mode == MODE_SEQUENCE) begin
                blocked = 1'b0;
                for (k = 0; k < n; k++) begin
                    if (int'(col_idx[k]) + 1 >= int'(cfg_rows[k])) begin
                        blocked = 1'b1;
                    end
                end
                if (blocked) begin
                    run_done = 1'b1;
                end else begin
                    for (k = 0; k < n; k++) begin
                        col_idx[k] = col_idx[k] + 16'd1;
                    end
                end
            end else begin
                k = n - 1;
                if (bump_column(k)) begin
                    // ripple the carry toward column zero
                    while (k > 0) begin
                        if (!bump_column(k - 1)) begin
                            break;
                        end
                        k--;
                    end
                    if (k == 0) begin
                        run_done = 1'b1;
                    end else if (cfg_mode == MODE_ASCENDING) begin
                        for (k = 1; k < n && !run_done; k++) begin
                            prev = int'(col_idx[k - 1]);
                            if (int'(col_idx[k]) <= prev) begin
                                if (prev + 1 >= int'(cfg_rows[k])) begin
                                    run_done = 1'b1;
                                end else begin
                                    col_idx[k] = RC_W'(prev + 1);
                                end
                            end
                        end
                    end
                end
            end
        end
        r.valid = !run_done;
        for (k = 0; k < OUT_COLUMNS; k++) begin
            r.idx[k] = (!run_done && k < n) ? col_idx[k] : '0;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_MODE) begin
            cfg_mode = t_mode'(data[1:0]);
        end else if (idx == CFG_COLUMN_COUNT) begin
            cfg_cols = data[COUNT_W-1:0];
        end else begin
            cfg_rows[idx - CFG_ROW_COUNT_0] = data;
        end
    endtask

    // partial: each register written with even odds; junk: noise in unused upper bits
    task automatic set_config(input logic [1:0] mode_v, input logic [2:0] cols_v,
                              input int r0, input int r1, input int r2,
                              input int r3, input int r4, input int r5,
                              input bit partial, input bit junk);
        logic [RC_W-1:0] rv [MAX_COLS];
        int              k;
        rv[0] = RC_W'(r0);
        rv[1] = RC_W'(r1);
        rv[2] = RC_W'(r2);
        rv[3] = RC_W'(r3);
        rv[4] = RC_W'(r4);
        rv[5] = RC_W'(r5);
        if (!partial || $urandom_range(0, 1)) begin
            write_reg(CFG_MODE, junk ? {14'($urandom), mode_v} : CFG_DATA_W'(mode_v));
        end
        if (!partial || $urandom_range(0, 1)) begin
            write_reg(CFG_COLUMN_COUNT, junk ? {13'($urandom), cols_v} : CFG_DATA_W'(cols_v));
        end
        for (k = 0; k < MAX_COLS; k++) begin
            if (!partial || $urandom_range(0, 1)) begin
                write_reg(CFG_INDEX_W'(int'(CFG_ROW_COUNT_0) + k), rv[k]);
            end
        end
        i_cfg_we <= 1'b0;
        configs_loaded++;
    endtask

    // hold off the input until every outstanding tuple is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (tuple_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_item(input logic restart);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (restart) begin
            restarts_sent++;
        end
        tuple_q.insert(tuple_q.size(), next_tuple(restart));
    endtask

    task automatic test_reset_state();
        // defaults: one column of one row, advance from the cleared state first
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_idle();
    endtask

    task automatic test_product_odometer();
        set_config(MODE_PRODUCT, 3'd3, 1, 2, 2, 1, 1, 1, 1'b0, 1'b0);
        send_item(1'b1);
        repeat (4) send_item(1'b0);
        wait_idle();
    endtask

    task automatic test_lockstep_sequence();
        set_config(MODE_SEQUENCE, 3'd2, 3, 5, 1, 1, 1, 1, 1'b0, 1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        wait_idle();
    endtask

    task automatic test_ascending_tuples();
        // carry then fix-up that runs out of rows
        set_config(MODE_ASCENDING, 3'd3, 3, 4, 3, 1, 1, 1, 1'b0, 1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_idle();
        set_config(MODE_ASCENDING, 3'd3, 3, 4, 5, 1, 1, 1, 1'b0, 1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        wait_idle();
        // start value of the last column not below its row count
        set_config(MODE_ASCENDING, 3'd3, 3, 4, 2, 1, 1, 1, 1'b0, 1'b0);
        send_item(1'b1);
        wait_idle();
    endtask

    task automatic test_degenerate_settings();
        set_config(MODE_PRODUCT_B, 3'd0, 2, 2, 2, 2, 2, 2, 1'b0, 1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_idle();
        // count above the column limit saturates
        set_config(MODE_PRODUCT_B, 3'd7, 2, 2, 2, 2, 2, 2, 1'b0, 1'b1);
        send_item(1'b1);
        send_item(1'b0);
        wait_idle();
        set_config(MODE_PRODUCT, 3'd1, 0, 2, 2, 2, 2, 2, 1'b0, 1'b0);
        send_item(1'b1);
        wait_idle();
        set_config(MODE_PRODUCT, 3'd1, 65535, 65535, 65535, 65535, 65535, 65535, 1'b0, 1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_idle();
    endtask

    task automatic test_random_walk();
        int         stop_at;
        int         phase_len;
        int         j;
        int         k;
        int         pick;
        int         rows [MAX_COLS];
        logic [1:0] mode_v;
        logic [2:0] cols_v;
        logic       restart;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            wait_idle();
            pick = $urandom_range(0, 9);
            mode_v = (pick < 3) ? MODE_PRODUCT : (pick < 6) ? MODE_SEQUENCE :
                     (pick < 9) ? MODE_ASCENDING : MODE_PRODUCT_B;
            pick = $urandom_range(0, 19);
            cols_v = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 : 3'($urandom_range(1, 6));
            for (k = 0; k < MAX_COLS; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    rows[k] = 0;
                end else if (pick == 1) begin
                    rows[k] = 65535;
                end else if (pick == 2) begin
                    rows[k] = $urandom_range(0, 65535);
                end else if (mode_v == MODE_ASCENDING) begin
                    rows[k] = $urandom_range(k + 1, k + 4);
                end else begin
                    rows[k] = $urandom_range(1, 4);
                end
            end
            set_config(mode_v, cols_v, rows[0], rows[1], rows[2], rows[3], rows[4], rows[5],
                       $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
            no_gaps = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 90);
            for (j = 0; j < phase_len; j++) begin
                // mostly restart then a run of advances, some stray restarts
                restart = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
                send_item(restart);
                if ($urandom_range(0, 149) == 0) begin
                    wait_idle();
                end
            end
        end
    endtask

    task automatic finish_run();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tuple_q.size() != 0) begin
            report_mismatch("tuples never returned", 0, tuple_q.size());
        end
        $display("covered %0d items (%0d restarts) over %0d register settings in all four modes",
                 items_sent, restarts_sent, configs_loaded);
        $display("checked %0d tuples, %0d of them past the end of the enumeration",
                 results_seen, exhausted_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_product_odometer();
        test_lockstep_sequence();
        test_ascending_tuples();
        test_degenerate_settings();
        test_random_walk();
        finish_run();
    end

    // output stall: the style is picked anew whenever its run count runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(32, 256);
        end else begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % 7;
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_phase < 3);
        endcase
    end

    // compare every returned tuple with the oldest prediction
    always @(posedge i_clk) begin
        t_tuple got;
        t_tuple want;
        int     k;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.valid  = o_valid_res;
            got.idx[0] = o_index_0;
            got.idx[1] = o_index_1;
            got.idx[2] = o_index_2;
            got.idx[3] = o_index_3;
            got.idx[4] = o_index_4;
            got.idx[5] = o_index_5;
            results_seen++;
            if (!got.valid) begin
                exhausted_seen++;
            end
            if (tuple_q.size() == 0) begin
                report_mismatch("unexpected transfer, valid_res", got.valid, 0);
            end else begin
                want = tuple_q.pop_front();
                if (got.valid !== want.valid) begin
                    report_mismatch("valid_res", got.valid, want.valid);
                end
                for (k = 0; k < OUT_COLUMNS; k++) begin
                    if (got.idx[k] !== want.idx[k]) begin
                        report_mismatch($sformatf("index_%0d", k), got.idx[k], want.idx[k]);
                    end
                end
            end
        end
    end

    // no transfer on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
